// ===== hdl/ldse_pkg.sv =====
// Shared types and constants for the leaky delta spike encoder.
// Depends on nothing; every other file of the block imports it.
package ldse_pkg;

  // Integrator store depth; a power of two no larger than the pixel index range.
  localparam int unsigned Pixels = 1024;
  localparam int unsigned SlotW = $clog2(Pixels);

  // Field and register widths.
  localparam int unsigned PixW = 10;
  localparam int unsigned IntenW = 17;
  localparam int unsigned LeakW = 16;
  localparam int unsigned ThrW = 24;
  localparam int unsigned AccW = 25;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 24;

  // The product keeps a sign bit on the leak and the full integrator width.
  localparam int unsigned ProdW = LeakW + 1 + AccW;
  // The sum of the scaled integrator and the intensity needs one more bit.
  localparam int unsigned SumW = AccW + 1;

  // Queue between the front and the back.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW = $clog2(QueueDepth);
  localparam int unsigned QCntW = $clog2(QueueDepth + 1);

  // Register reset values.
  localparam logic [LeakW-1:0] LeakReset = 16'd62259;
  localparam logic [ThrW-1:0] ThreshReset = 24'd3277;

  // Largest value the signed Q8.16 integrator can hold.
  localparam logic signed [SumW-1:0] AccMax = SumW'((1 << (AccW - 1)) - 1);

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgLeak   = 1'b0,
    CfgThresh = 1'b1
  } cfg_idx_e;

  // Spike codes as they appear on the output.
  localparam logic [1:0] SpikeNone = 2'b00;
  localparam logic [1:0] SpikePos = 2'b01;
  localparam logic [1:0] SpikeNeg = 2'b11;

  typedef logic signed [AccW-1:0] acc_t;

  // One classified input item as it travels through the queue.
  typedef struct packed {
    logic [SlotW-1:0]  slot;
    logic [PixW-1:0]   pixel;
    logic [IntenW-1:0] intensity;
    logic              restart;
  } item_t;

  // Live configuration seen by the back end.
  typedef struct packed {
    logic [LeakW-1:0] leak;
    logic [ThrW-1:0]  thresh;
  } cfg_t;

endpackage

// ===== hdl/ldse_front.sv =====
// Front end: configuration registers, input handshake and item classification.
// Depends on ldse_pkg.
module ldse_front
  import ldse_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [PixW-1:0]     pixel_index_i,
  input  logic [IntenW-1:0]   intensity_i,
  input  logic                restart_i,
  input  logic                q_full_i,
  output logic                push_o,
  output item_t               item_o,
  output cfg_t                cfg_o
);

  logic [LeakW-1:0] leak_q;
  logic [ThrW-1:0]  thresh_q;

  // Configuration writes land directly in their register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leak_q   <= LeakReset;
      thresh_q <= ThreshReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgLeak:   leak_q   <= cfg_wdata_i[LeakW-1:0];
        CfgThresh: thresh_q <= cfg_wdata_i[ThrW-1:0];
      endcase
    end
  end

  assign cfg_o.leak   = leak_q;
  assign cfg_o.thresh = thresh_q;

  // An item is taken whenever the queue has room.
  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && in_ready_o;

  // Reduce the pixel index to its integrator slot; the store depth is a power of two.
  assign item_o.slot      = pixel_index_i[SlotW-1:0];
  assign item_o.pixel     = pixel_index_i;
  assign item_o.intensity = intensity_i;
  assign item_o.restart   = restart_i;

endmodule

// ===== hdl/ldse_queue.sv =====
// Short item queue that decouples the front end from the back end.
// Depends on ldse_pkg.
module ldse_queue
  import ldse_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  head_valid_o,
  output item_t head_o
);

  item_t             entries_q [QueueDepth];
  logic [QPtrW-1:0]  wr_ptr_q;
  logic [QPtrW-1:0]  rd_ptr_q;
  logic [QCntW-1:0]  count_q;

  assign full_o       = (count_q == QCntW'(QueueDepth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = entries_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCntW'(1);
      end
    end
  end

  // Item storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= item_i;
    end
  end

  // The front never pushes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) full_o |-> !push_i)
    else $error("item pushed into a full queue");

  // The back never pops an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> head_valid_o)
    else $error("item popped from an empty queue");

endmodule

// ===== hdl/ldse_back.sv =====
// Back end: integrator store, multiply stage, add/threshold stage and output register.
// Depends on ldse_pkg.
module ldse_back
  import ldse_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             head_valid_i,
  input  item_t            head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic signed [1:0] spike_o,
  output logic [PixW-1:0]  pixel_echo_o
);

  // Integrator store, undefined until a restart writes an entry.
  logic [AccW-1:0] mem [Pixels];
  logic [AccW-1:0] rd_q;

  logic             s1_valid_q;
  item_t            s1_item_q;
  logic             s2_valid_q;
  item_t            s2_item_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [ProdW-1:0] prod_d;
  logic             out_valid_q;
  logic [1:0]       spike_q;
  logic [PixW-1:0]  pixel_q;

  logic             adv;
  logic             hazard;
  logic             issue;

  acc_t                    stored;
  acc_t                    prod_sh;
  logic signed [SumW-1:0]  sum;
  logic signed [SumW-1:0]  sat;
  logic signed [SumW-1:0]  thr;
  logic signed [SumW-1:0]  next_v;
  logic [1:0]              spike_d;

  // The whole pipeline moves when the output register is free or being emptied.
  assign adv = !out_valid_q || out_ready_i;

  // An item waits while an earlier item for the same slot has not written back yet.
  assign hazard = (s1_valid_q && (s1_item_q.slot == head_i.slot)) ||
                  (s2_valid_q && (s2_item_q.slot == head_i.slot));
  assign issue  = head_valid_i && adv && !hazard;
  assign pop_o  = issue;

  // Stage one: stored value (zero on restart) times the leak.
  assign stored = s1_item_q.restart ? '0 : acc_t'(rd_q);
  assign prod_d = $signed({{(ProdW - LeakW){1'b0}}, cfg_i.leak}) *
                  $signed({{(ProdW - AccW){stored[AccW-1]}}, stored});

  // Stage two: arithmetic shift by 16, add intensity, saturate, threshold.
  assign prod_sh = prod_q[LeakW +: AccW];
  assign sum     = $signed({prod_sh[AccW-1], prod_sh}) +
                   $signed({{(SumW - IntenW){1'b0}}, s2_item_q.intensity});
  // The scaled integrator stays above the negative limit, so only the top clamps.
  assign sat     = (sum > AccMax) ? AccMax : sum;
  assign thr     = $signed({{(SumW - ThrW){1'b0}}, cfg_i.thresh});

  always_comb begin
    if (sat > thr) begin
      spike_d = SpikePos;
      next_v  = sat - thr;
    end else if (sat < -thr) begin
      spike_d = SpikeNeg;
      next_v  = sat + thr;
    end else begin
      spike_d = SpikeNone;
      next_v  = sat;
    end
  end

  // Store read at issue and write-back from stage two.
  always_ff @(posedge clk_i) begin
    if (s2_valid_q && adv) begin
      mem[s2_item_q.slot] <= next_v[AccW-1:0];
    end
    if (issue) begin
      rd_q <= mem[head_i.slot];
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= issue;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_item_q <= head_i;
    end
    if (adv) begin
      s2_item_q <= s1_item_q;
      prod_q    <= prod_d;
      spike_q   <= spike_d;
      pixel_q   <= s2_item_q.pixel;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign spike_o      = $signed(spike_q);
  assign pixel_echo_o = pixel_q;

  // Two items for one slot are never in the multiply and add stages together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s2_valid_q) |-> (s1_item_q.slot != s2_item_q.slot))
    else $error("same slot in flight twice");

  // A finished item shows up on the output with its own pixel index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && adv) |=> (out_valid_q && (pixel_q == $past(s2_item_q.pixel))))
    else $error("finished item lost on the way to the output");

  // The spike code is always one of the three legal codes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (spike_q == SpikeNone || spike_q == SpikePos || spike_q == SpikeNeg))
    else $error("illegal spike code");

endmodule

// ===== hdl/leaky_delta_spike_encoder_core.sv =====
// Top level of the leaky delta spike encoder.
// Depends on ldse_pkg, ldse_front, ldse_queue and ldse_back.
//
// Usage:
// Input items (pixel index, Q1.16 intensity, restart flag) arrive on a
// valid/ready channel; each produces exactly one result item (bipolar spike
// and the pixel index echoed) on a valid/ready output channel, in order.
// A restart item treats the pixel's integrator as zero; every pixel must see
// a restart before its integrator is otherwise used.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i at the
// clock edge (0 = leak factor, 1 = spike threshold); write only when idle.
// Path: an accepted item passes the queue, stage one (store read and multiply),
// stage two (add and threshold) and the output register.
// Throughput: one item per cycle while the receiver keeps up, unless an item
// names the pixel of one of the two items before it; it then waits in the
// queue until that item has written back. The store's read-modify-write loop
// sets this.
// Reset clears the queue, the pipeline and the output register and loads the
// register reset values; the integrator store is not cleared.
// When the receiver stalls the output register holds and the pipeline
// freezes; the four-entry queue keeps accepting input until it fills.
module leaky_delta_spike_encoder_core
  import ldse_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [PixW-1:0]      pixel_index_i,
  input  logic [IntenW-1:0]    intensity_i,
  input  logic                 restart_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [1:0]    spike_o,
  output logic [PixW-1:0]      pixel_echo_o
);

  logic  q_full;
  logic  push;
  item_t item;
  cfg_t  cfg;
  logic  pop;
  logic  head_valid;
  item_t head;

  // Front end: configuration and input handshake.
  ldse_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pixel_index_i (pixel_index_i),
    .intensity_i   (intensity_i),
    .restart_i     (restart_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .item_o        (item),
    .cfg_o         (cfg)
  );

  // Item queue between the two halves.
  ldse_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .item_i       (item),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // Back end: integrator update and result delivery.
  ldse_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .spike_o      (spike_o),
    .pixel_echo_o (pixel_echo_o)
  );

endmodule

// ===== tb/leaky_delta_spike_encoder_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for leaky_delta_spike_encoder_core.
// Depends on ldse_pkg and the core; it predicts every spike with its own
// per-pixel integrator copy and checks results in order under random idling.
module leaky_delta_spike_encoder_core_tb;
  import ldse_pkg::*;

  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned SettleCycles = 8;
  localparam longint AccHi = (longint'(1) << (AccW - 1)) - 1;
  localparam longint AccLo = -(longint'(1) << (AccW - 1));

  // One result item as the block should produce it.
  typedef struct packed {
    logic [1:0]      spike;
    logic [PixW-1:0] pixel;
  } spike_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i = CfgLeak;
  logic [CfgDataW-1:0]  cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [PixW-1:0]      pixel_index_i = '0;
  logic [IntenW-1:0]    intensity_i = '0;
  logic                 restart_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic signed [1:0]    spike_o;
  logic [PixW-1:0]      pixel_echo_o;

  // Predictor state: configuration copy and one integrator per pixel.
  logic [LeakW-1:0] leak_q = LeakReset;
  logic [ThrW-1:0]  thr_q = ThreshReset;
  acc_t             integ_mem [Pixels];
  bit               primed [Pixels];
  spike_result_t    predicted_spikes [$];

  int unsigned error_count = 0;
  int unsigned accepted_items = 0;
  int unsigned checked_results = 0;
  int unsigned pos_spikes = 0;
  int unsigned clamp_hits = 0;
  int unsigned settings_applied = 0;
  int unsigned quiet_cycles = 0;
  int unsigned tx_burst = 0;
  bit          long_hold_req = 1'b0;

  leaky_delta_spike_encoder_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .pixel_index_i(pixel_index_i),
    .intensity_i  (intensity_i),
    .restart_i    (restart_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .spike_o      (spike_o),
    .pixel_echo_o (pixel_echo_o)
  );

  always #5 clk_i = ~clk_i;

  // Leaky integrate, clamp to Q8.16, compare against the threshold and write back.
  function automatic spike_result_t predict_spike(input logic [PixW-1:0] pix,
                                                  input logic [IntenW-1:0] inten,
                                                  input logic fresh);
    spike_result_t res;
    longint held;
    longint level;
    longint thr;
    held = fresh ? longint'(0) : longint'(integ_mem[pix]);
    level = ((longint'(leak_q) * held) >>> 16) + longint'(inten);
    if (level > AccHi) begin
      level = AccHi;
      clamp_hits++;
    end
    if (level < AccLo) begin
      level = AccLo;
      clamp_hits++;
    end
    thr = longint'(thr_q);
    if (level > thr) begin
      res.spike = SpikePos;
      level -= thr;
      pos_spikes++;
    end else if (level < -thr) begin
      res.spike = SpikeNeg;
      level += thr;
    end else begin
      res.spike = SpikeNone;
    end
    integ_mem[pix] = acc_t'(level);
    res.pixel = pix;
    return res;
  endfunction

  // Mostly in-range intensities, with both ends and values above 1.0 mixed in.
  function automatic logic [IntenW-1:0] draw_intensity();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return IntenW'(65536);
      2: return IntenW'($urandom_range(65537, 131071));
      default: return IntenW'($urandom_range(0, 65535));
    endcase
  endfunction

  // Predict each item at the edge where it is accepted.
  always @(posedge clk_i) begin : intake_monitor
    if (rst_ni && in_valid_i && in_ready_o) begin
      predicted_spikes.push_back(predict_spike(pixel_index_i, intensity_i, restart_i));
      accepted_items++;
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk_i) begin : result_checker
    spike_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (predicted_spikes.size() == 0) begin
        $error("result with no item outstanding: spike %0d, pixel_echo %0d",
               spike_o, pixel_echo_o);
        error_count++;
      end else begin
        want = predicted_spikes.pop_front();
        if (spike_o !== want.spike) begin
          $error("spike: expected %0d, actual %0d", $signed(want.spike), spike_o);
          error_count++;
        end
        if (pixel_echo_o !== want.pixel) begin
          $error("pixel_echo: expected %0d, actual %0d", want.pixel, pixel_echo_o);
          error_count++;
        end
        checked_results++;
      end
    end
  end

  // End the run if no item moves on either side for too long.
  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles == QuietLimit) begin
      $display("leaky_delta_spike_encoder_core verification failed");
      $finish;
    end
  end

  // Receiver: random stalls per item, stall-free stretches and one long hold-off.
  initial begin : result_sink
    int unsigned stall;
    int unsigned rx_burst;
    rx_burst = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall = HoldCycles;
      end else if (rx_burst != 0) begin
        stall = 0;
        rx_burst--;
      end else if ($urandom_range(0, 9) == 0) begin
        stall = 0;
        rx_burst = $urandom_range(20, 60);
      end else begin
        stall = $urandom_range(0, 12);
      end
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  // Offer one item after a random gap and hold it until accepted. A pixel
  // that has never been restarted gets a restart so no unwritten entry is read.
  task automatic send_item(input logic [PixW-1:0] pix, input logic [IntenW-1:0] inten,
                           input logic fresh);
    int unsigned gap;
    if (tx_burst != 0) begin
      gap = 0;
      tx_burst--;
    end else if ($urandom_range(0, 9) == 0) begin
      gap = 0;
      tx_burst = $urandom_range(20, 60);
    end else begin
      gap = $urandom_range(0, 12);
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pixel_index_i <= pix;
    intensity_i   <= inten;
    restart_i     <= fresh | ~primed[pix];
    primed[pix] = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stop offering and wait until every predicted result has come out.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (predicted_spikes.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write both registers on back-to-back edges; leak data carries random upper bits.
  task automatic apply_config(input logic [LeakW-1:0] leak, input logic [ThrW-1:0] thr);
    logic [CfgDataW-LeakW-1:0] filler;
    filler = (CfgDataW - LeakW)'($urandom);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgLeak;
    cfg_wdata_i <= {filler, leak};
    @(posedge clk_i);
    cfg_idx_i   <= CfgThresh;
    cfg_wdata_i <= thr;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    leak_q = leak;
    thr_q = thr;
    settings_applied++;
  endtask

  // Field extremes, same-pixel hazards, zero threshold, no leak and full leak.
  task automatic test_directed();
    send_item(PixW'(0), IntenW'(0), 1'b1);
    send_item(PixW'(1023), IntenW'(131071), 1'b1);
    send_item(PixW'(1023), IntenW'(0), 1'b0);
    send_item(PixW'(512), IntenW'(65536), 1'b1);
    send_item(PixW'(512), IntenW'(65536), 1'b0);
    send_item(PixW'('h155), IntenW'('h0AAAA), 1'b1);
    send_item(PixW'('h2AA), IntenW'('h15555), 1'b1);
    send_item(PixW'(0), IntenW'(1), 1'b0);
    send_item(PixW'(1023), IntenW'(100), 1'b1);
    drain();
    // With a zero threshold any positive level spikes and is kept as it is.
    apply_config(LeakReset, '0);
    send_item(PixW'(0), IntenW'(0), 1'b1);
    send_item(PixW'(5), IntenW'(1), 1'b1);
    send_item(PixW'(5), IntenW'(0), 1'b0);
    send_item(PixW'(5), IntenW'(0), 1'b0);
    drain();
    // Without leak the integrator holds only the new intensity.
    apply_config('0, ThreshReset);
    send_item(PixW'(1023), IntenW'(3000), 1'b0);
    send_item(PixW'(1023), IntenW'(3000), 1'b0);
    drain();
    // Full leak and the largest threshold: the level only grows.
    apply_config('1, '1);
    send_item(PixW'(7), IntenW'(131071), 1'b1);
    send_item(PixW'(7), IntenW'(131071), 1'b0);
    drain();
  endtask

  // Drive four pixels into the Q8.16 ceiling, then spike from the clamped level.
  task automatic test_saturation();
    logic [PixW-1:0] base;
    base = PixW'($urandom_range(0, 1019));
    apply_config('1, '1);
    for (int r = 0; r < 190; r++) begin
      for (int k = 0; k < 4; k++) begin
        send_item(base + PixW'(k), IntenW'($urandom_range(98304, 131071)), 1'b0);
      end
    end
    drain();
    apply_config('1, ThrW'('hF00000));
    for (int r = 0; r < 10; r++) begin
      for (int k = 0; k < 4; k++) begin
        send_item(base + PixW'(k), draw_intensity(), 1'b0);
      end
    end
    drain();
  endtask

  // The receiver holds off for a long stretch while items keep coming.
  task automatic test_input_stall();
    apply_config(LeakReset, ThrW'(20000));
    long_hold_req = 1'b1;
    for (int i = 0; i < 64; i++) begin
      send_item(PixW'(i * 16 + 3), draw_intensity(), 1'b0);
    end
    drain();
  endtask

  // Random phases, each under its own setting; half the items hit a small
  // set of pixels so that read-after-write hazards are frequent.
  task automatic test_random_phases();
    logic [PixW-1:0]   hot [8];
    logic [PixW-1:0]   pix;
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: apply_config(LeakW'($urandom), ThrW'($urandom_range(0, 70000)));
        1: apply_config('0, '0);
        2: apply_config('1, '1);
        3: apply_config(LeakW'($urandom), ThrW'($urandom));
        default: apply_config(LeakReset, ThreshReset);
      endcase
      foreach (hot[h]) hot[h] = PixW'($urandom);
      for (int i = 0; i < 220; i++) begin
        pix = $urandom_range(0, 1) ? hot[$urandom_range(0, 7)] : PixW'($urandom);
        send_item(pix, draw_intensity(), $urandom_range(0, 11) == 0);
      end
      drain();
    end
  endtask

  initial begin : test_sequence
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_saturation();
    test_input_stall();
    test_random_phases();
    if (predicted_spikes.size() != 0) begin
      $error("%0d predicted results never arrived", predicted_spikes.size());
      error_count++;
    end
    $display("Run covered %0d items and %0d checked results under %0d register settings,",
             accepted_items, checked_results, settings_applied);
    $display("with %0d positive spikes and %0d clamped sums.", pos_spikes, clamp_hits);
    if (error_count == 0) begin
      $display("leaky_delta_spike_encoder_core verification clean");
    end else begin
      $display("leaky_delta_spike_encoder_core verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/ldse_pkg.sv
hdl/ldse_front.sv
hdl/ldse_queue.sv
hdl/ldse_back.sv
hdl/leaky_delta_spike_encoder_core.sv
tb/leaky_delta_spike_encoder_core_tb.sv
